// ===== sv/tlop_pkg.sv =====
package tlop_pkg;

    localparam int MAX_STEPS = 1024;
    localparam int LINE_LEN  = 2 * MAX_STEPS + 1;
    localparam int ADDR_W    = $clog2(LINE_LEN);
    localparam int STEP_W    = 13;
    localparam int Q_W       = 48;

    typedef logic signed [Q_W-1:0] q_t;

    localparam q_t QMAX = 48'sh7FFF_FFFF_FFFF;
    localparam q_t QMIN = 48'sh8000_0000_0000;
    localparam q_t QONE = 48'sh0000_0100_0000;

    // Divider request and response between the sequencer and the divide unit
    typedef struct packed {
        logic start;
        q_t   num;
        q_t   den;
    } div_req_t;

    typedef struct packed {
        logic done;
        q_t   quo;
    } div_rsp_t;

    // Magnitude of a 48-bit signed value; the most negative value maps to 2^47
    function automatic logic [Q_W-1:0] q_mag(input q_t a);
        return a[Q_W-1] ? (~a + 48'd1) : a;
    endfunction

    // Apply a sign to a magnitude and saturate into 48 bits
    function automatic q_t q_signed_sat(input logic [49:0] m, input logic neg);
        if (neg)
        begin
            if (m >= 50'h0_8000_0000_0000)
                return QMIN;
            return q_t'(~m[Q_W-1:0] + 48'd1);
        end
        if (m > 50'h0_7FFF_FFFF_FFFF)
            return QMAX;
        return q_t'(m[Q_W-1:0]);
    endfunction

    function automatic q_t q_sat50(input logic signed [49:0] v);
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111)
            return q_t'(v[Q_W-1:0]);
        return v[49] ? QMIN : QMAX;
    endfunction

    function automatic q_t q_sub(input q_t a, input q_t b);
        logic signed [Q_W:0] d;
        d = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (d[Q_W] != d[Q_W-1])
            return d[Q_W] ? QMIN : QMAX;
        return q_t'(d[Q_W-1:0]);
    endfunction

endpackage

// ===== sv/tlop_ram.sv =====
module tlop_ram #(
    parameter int DEPTH = 2049,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/tlop_qmul.sv =====
module tlop_qmul (
    input  logic        clk,
    input  tlop_pkg::q_t a,
    input  tlop_pkg::q_t b,
    output tlop_pkg::q_t p
);

    import tlop_pkg::*;

    logic [Q_W-1:0] ua;
    logic [Q_W-1:0] ub;
    logic [47:0]    ll_reg;
    logic [47:0]    lh_reg;
    logic [47:0]    hl_reg;
    logic [47:0]    hh_reg;
    logic           neg_reg;
    logic [49:0]    sum;

    assign ua = q_mag(a);
    assign ub = q_mag(b);

    // Stage one: four 24x24 partial products
    always_ff @(posedge clk)
    begin
        neg_reg <= a[Q_W-1] ^ b[Q_W-1];
        ll_reg  <= ua[23:0] * ub[23:0];
        lh_reg  <= ua[23:0] * ub[47:24];
        hl_reg  <= ua[47:24] * ub[23:0];
        hh_reg  <= ua[47:24] * ub[47:24];
    end

    assign sum = {2'b00, hh_reg[23:0], 24'd0} + {2'b00, hl_reg} + {2'b00, lh_reg}
               + {26'd0, ll_reg[47:24]};

    // Stage two: combine, drop the low 24 bits, saturate
    always_ff @(posedge clk)
    begin
        if (|hh_reg[47:24])
            p <= neg_reg ? QMIN : QMAX;
        else
            p <= q_signed_sat(sum, neg_reg);
    end

endmodule

// ===== sv/tlop_qdiv.sv =====
module tlop_qdiv (
    input  logic                clk,
    input  logic                rst_n,
    input  tlop_pkg::div_req_t  req,
    output tlop_pkg::div_rsp_t  rsp
);

    import tlop_pkg::*;

    localparam int DivSteps = 72;
    localparam int CntW     = $clog2(DivSteps + 1);

    logic            busy_reg;
    logic [CntW-1:0] cnt_reg;
    logic [71:0]     dvd_reg;
    logic [47:0]     rem_reg;
    logic [71:0]     quo_reg;
    logic [47:0]     ub_reg;
    logic            neg_reg;
    logic            zero_reg;
    logic            done_reg;
    q_t              res_reg;
    logic [48:0]     rem_sh;
    logic            ge;
    logic [48:0]     rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[71]};
    assign ge      = rem_sh >= {1'b0, ub_reg};
    assign rem_sub = rem_sh - {1'b0, ub_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            ub_reg   <= '0;
            neg_reg  <= 1'b0;
            zero_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(DivSteps);
                dvd_reg  <= {q_mag(req.num), 24'd0};
                rem_reg  <= '0;
                quo_reg  <= '0;
                ub_reg   <= q_mag(req.den);
                neg_reg  <= req.num[Q_W-1] ^ req.den[Q_W-1];
                zero_reg <= (req.den == '0);
            end
            else if (busy_reg && cnt_reg != '0)
            begin
                // Restoring division, one quotient bit per cycle
                rem_reg <= ge ? rem_sub[47:0] : rem_sh[47:0];
                quo_reg <= {quo_reg[70:0], ge};
                dvd_reg <= {dvd_reg[70:0], 1'b0};
                cnt_reg <= cnt_reg - CntW'(1);
            end
            else if (busy_reg)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                if (zero_reg)
                    res_reg <= '0;
                else if (|quo_reg[71:48])
                    res_reg <= neg_reg ? QMIN : QMAX;
                else
                    res_reg <= q_signed_sat({2'b00, quo_reg[47:0]}, neg_reg);
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = res_reg;

endmodule

// ===== sv/trinomial_lattice_option_pricer_top.sv =====
// Trinomial lattice option pricer. Load spot, strike, call/put and American
// through the cfg port, then send one request per pricing run carrying the
// step count n and the precomputed lattice factors (Q24.24). The block builds
// the terminal spot line S*u^k and S*d^k by chained multiplies, writing the
// terminal payoffs as it goes, then runs backward induction one lattice node
// per cycle, bounded by the single read port of the node memory, with a
// pipeline drain after each level. Delta, gamma and theta come from a shared
// divider after each of the last three levels; only one request is in flight,
// and a finished result waits in the output register while the next request
// is accepted. A step count outside 3..1024 returns at once with bad_steps set
// and all other fields zero. Memories need no clearing after reset.
module trinomial_lattice_option_pricer_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_addr,
    input  logic [46:0]    cfg_wdata,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // steps[12:0], up_factor[60:13], down_factor[108:61], prob_up[156:109],
    // prob_mid[204:157], prob_down[252:205], step_time[299:253], zero pad
    input  logic [303:0]   s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // option_value[47:0], delta_out[95:48], gamma_out[143:96], theta_out[191:144]
    output logic [191:0]   m_axis_tdata,
    // bad_steps[0]
    output logic [0:0]     m_axis_tuser
);

    import tlop_pkg::*;

    localparam logic [1:0] RegSpot   = 2'd0;
    localparam logic [1:0] RegStrike = 2'd1;
    localparam logic [1:0] RegCall   = 2'd2;
    localparam logic [1:0] RegAmer   = 2'd3;

    localparam logic [ADDR_W-1:0] Mid = ADDR_W'(MAX_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_INIT, ST_CHAIN, ST_LEVEL, ST_GREEK, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_G_DIFF, OP_G_A, OP_G_LOW, OP_G_B, OP_G_MIX, OP_GAMMA,
        OP_D_DIFF, OP_DELTA, OP_THETA
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    logic [46:0] spot_reg;
    logic [46:0] strike_reg;
    logic        is_call_reg;
    logic        is_amer_reg;

    logic [ADDR_W-1:0] n_reg;
    q_t up_reg, dn_reg, pu_reg, pm_reg, pd_reg, dt_reg;
    q_t uu_reg, dd_reg;

    logic              dir_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [1:0]        phase_reg;
    q_t                cur_reg;

    logic [ADDR_W-1:0] lvl_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic              rd_on_reg;
    logic              ret_valid_reg;
    logic [ADDR_W-1:0] ret_idx_reg;
    q_t                w0_reg, w1_reg;
    logic              m1_valid_reg, m2_valid_reg;
    logic [ADDR_W-1:0] m1_j_reg, m2_j_reg;
    q_t                m1_ex_reg, m2_ex_reg;

    logic              nwr_valid_reg;
    logic [ADDR_W-1:0] nwr_addr_reg;
    q_t                nwr_data_reg;
    logic              swr_valid_reg;
    logic [ADDR_W-1:0] swr_addr_reg;
    q_t                swr_data_reg;

    q_t   cap_reg [5];
    logic div_wait_reg;
    q_t   t0_reg, t1_reg, delta_reg, gamma_reg, theta_reg;
    logic bad_reg;

    logic out_valid_reg;
    q_t   out_value_reg, out_delta_reg, out_gamma_reg, out_theta_reg;
    logic out_bad_reg;

    q_t node_rdata, spot_rdata;
    logic [ADDR_W-1:0] node_raddr, spot_raddr;
    q_t mul_a_x, mul_a_y, mul_b_x, mul_b_y, mul_c_x, mul_c_y;
    q_t mul_a_p, mul_b_p, mul_c_p;

    div_req_t div_req;
    div_rsp_t div_rsp;

    q_t   spot_q, strike_q;
    logic put_floor;
    logic in_level;
    logic rd_last;
    logic level_idle;
    logic [STEP_W-1:0] in_steps;
    logic in_bad;
    q_t   branch_sum, node_val;

    assign spot_q    = q_t'({1'b0, spot_reg});
    assign strike_q  = q_t'({1'b0, strike_reg});
    assign put_floor = !is_call_reg && is_amer_reg;
    assign in_level  = (state_reg == ST_LEVEL);

    assign in_steps = s_axis_tdata[STEP_W-1:0];
    assign in_bad   = (in_steps < STEP_W'(3)) || (in_steps > STEP_W'(MAX_STEPS));

    function automatic q_t payoff(input q_t s, input q_t k, input logic call);
        q_t v;
        v = call ? q_sub(s, k) : q_sub(k, s);
        return v[Q_W-1] ? '0 : v;
    endfunction

    // Read side: node p[rd_idx] and spot at level offset lvl - j, j = rd_idx - 2
    assign rd_last    = (rd_idx_reg == ({lvl_reg[ADDR_W-2:0], 1'b0} + ADDR_W'(2)));
    assign node_raddr = rd_idx_reg;
    assign spot_raddr = (rd_idx_reg < ADDR_W'(2)) ? Mid
                      : (Mid + lvl_reg + ADDR_W'(2) - rd_idx_reg);
    assign level_idle = !rd_on_reg && !ret_valid_reg && !m1_valid_reg
                      && !m2_valid_reg && !nwr_valid_reg;

    // Multiplier operand steering: chain / squares, or the three branches
    assign mul_a_x = in_level ? pu_reg : cur_reg;
    assign mul_a_y = in_level ? w0_reg : (dir_reg ? dn_reg : up_reg);
    assign mul_b_x = in_level ? pm_reg : up_reg;
    assign mul_b_y = in_level ? w1_reg : up_reg;
    assign mul_c_x = in_level ? pd_reg : dn_reg;
    assign mul_c_y = in_level ? node_rdata : dn_reg;

    assign branch_sum = q_sat50({{2{mul_a_p[Q_W-1]}}, mul_a_p}
                              + {{2{mul_b_p[Q_W-1]}}, mul_b_p}
                              + {{2{mul_c_p[Q_W-1]}}, mul_c_p});
    assign node_val   = (put_floor && (branch_sum < m2_ex_reg)) ? m2_ex_reg : branch_sum;

    tlop_ram #(.DEPTH(LINE_LEN), .WIDTH(Q_W)) u_node_ram (
        .clk   (clk),
        .we    (nwr_valid_reg),
        .waddr (nwr_addr_reg),
        .wdata (nwr_data_reg),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    tlop_ram #(.DEPTH(LINE_LEN), .WIDTH(Q_W)) u_spot_ram (
        .clk   (clk),
        .we    (swr_valid_reg),
        .waddr (swr_addr_reg),
        .wdata (swr_data_reg),
        .raddr (spot_raddr),
        .rdata (spot_rdata)
    );

    tlop_qmul u_mul_a (.clk(clk), .a(mul_a_x), .b(mul_a_y), .p(mul_a_p));
    tlop_qmul u_mul_b (.clk(clk), .a(mul_b_x), .b(mul_b_y), .p(mul_b_p));
    tlop_qmul u_mul_c (.clk(clk), .a(mul_c_x), .b(mul_c_y), .p(mul_c_p));

    // Greek sequence operands
    always_comb
    begin
        div_req.start = (state_reg == ST_GREEK) && !div_wait_reg;
        case (op_reg)
            OP_G_DIFF: begin div_req.num = q_sub(cap_reg[0], cap_reg[2]); div_req.den = spot_q; end
            OP_G_A:    begin div_req.num = t0_reg; div_req.den = q_sub(uu_reg, QONE); end
            OP_G_LOW:  begin div_req.num = q_sub(cap_reg[2], cap_reg[4]); div_req.den = spot_q; end
            OP_G_B:    begin div_req.num = t1_reg; div_req.den = q_sub(QONE, dd_reg); end
            OP_G_MIX:  begin div_req.num = q_sub(t0_reg, t1_reg); div_req.den = spot_q; end
            OP_GAMMA:  begin div_req.num = t0_reg; div_req.den = q_sub(up_reg, dn_reg); end
            OP_D_DIFF: begin div_req.num = q_sub(cap_reg[0], cap_reg[2]); div_req.den = spot_q; end
            OP_DELTA:  begin div_req.num = t0_reg; div_req.den = q_sub(up_reg, dn_reg); end
            OP_THETA:  begin div_req.num = q_sub(cap_reg[1], cap_reg[0]); div_req.den = dt_reg; end
            default:   begin div_req.num = '0; div_req.den = '0; end
        endcase
    end

    tlop_qdiv u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_G_DIFF;
            spot_reg      <= '0;
            strike_reg    <= '0;
            is_call_reg   <= 1'b0;
            is_amer_reg   <= 1'b0;
            n_reg         <= '0;
            up_reg        <= '0;
            dn_reg        <= '0;
            pu_reg        <= '0;
            pm_reg        <= '0;
            pd_reg        <= '0;
            dt_reg        <= '0;
            uu_reg        <= '0;
            dd_reg        <= '0;
            dir_reg       <= 1'b0;
            k_reg         <= '0;
            phase_reg     <= '0;
            cur_reg       <= '0;
            lvl_reg       <= '0;
            rd_idx_reg    <= '0;
            rd_on_reg     <= 1'b0;
            ret_valid_reg <= 1'b0;
            ret_idx_reg   <= '0;
            w0_reg        <= '0;
            w1_reg        <= '0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m1_j_reg      <= '0;
            m2_j_reg      <= '0;
            m1_ex_reg     <= '0;
            m2_ex_reg     <= '0;
            nwr_valid_reg <= 1'b0;
            nwr_addr_reg  <= '0;
            nwr_data_reg  <= '0;
            swr_valid_reg <= 1'b0;
            swr_addr_reg  <= '0;
            swr_data_reg  <= '0;
            for (int e = 0; e < 5; e++)
                cap_reg[e] <= '0;
            div_wait_reg  <= 1'b0;
            t0_reg        <= '0;
            t1_reg        <= '0;
            delta_reg     <= '0;
            gamma_reg     <= '0;
            theta_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_delta_reg <= '0;
            out_gamma_reg <= '0;
            out_theta_reg <= '0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            // Configuration, written only while idle by contract, not enforced
            if (cfg_we)
            begin
                case (cfg_addr)
                    RegSpot:   spot_reg    <= cfg_wdata;
                    RegStrike: strike_reg  <= cfg_wdata;
                    RegCall:   is_call_reg <= cfg_wdata[0];
                    RegAmer:   is_amer_reg <= cfg_wdata[0];
                    default:   ;
                endcase
            end

            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            nwr_valid_reg <= 1'b0;
            swr_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        n_reg   <= in_steps[ADDR_W-1:0];
                        up_reg  <= q_t'(s_axis_tdata[60:13]);
                        dn_reg  <= q_t'(s_axis_tdata[108:61]);
                        pu_reg  <= q_t'(s_axis_tdata[156:109]);
                        pm_reg  <= q_t'(s_axis_tdata[204:157]);
                        pd_reg  <= q_t'(s_axis_tdata[252:205]);
                        dt_reg  <= q_t'({1'b0, s_axis_tdata[299:253]});
                        bad_reg <= in_bad;
                        state_reg <= in_bad ? ST_DONE : ST_INIT;
                    end
                end

                ST_INIT:
                begin
                    // Center of the terminal line
                    swr_valid_reg <= 1'b1;
                    swr_addr_reg  <= Mid;
                    swr_data_reg  <= spot_q;
                    nwr_valid_reg <= 1'b1;
                    nwr_addr_reg  <= n_reg;
                    nwr_data_reg  <= payoff(spot_q, strike_q, is_call_reg);
                    cur_reg   <= spot_q;
                    k_reg     <= ADDR_W'(1);
                    dir_reg   <= 1'b0;
                    phase_reg <= '0;
                    state_reg <= ST_CHAIN;
                end

                ST_CHAIN:
                begin
                    if (phase_reg != 2'd2)
                        phase_reg <= phase_reg + 2'd1;
                    else
                    begin
                        phase_reg     <= '0;
                        swr_valid_reg <= 1'b1;
                        swr_addr_reg  <= dir_reg ? (Mid - k_reg) : (Mid + k_reg);
                        swr_data_reg  <= mul_a_p;
                        nwr_valid_reg <= 1'b1;
                        nwr_addr_reg  <= dir_reg ? (n_reg + k_reg) : (n_reg - k_reg);
                        nwr_data_reg  <= payoff(mul_a_p, strike_q, is_call_reg);
                        cur_reg       <= mul_a_p;
                        k_reg         <= k_reg + ADDR_W'(1);
                        if (k_reg == n_reg)
                        begin
                            if (!dir_reg)
                            begin
                                dir_reg <= 1'b1;
                                cur_reg <= spot_q;
                                k_reg   <= ADDR_W'(1);
                            end
                            else
                            begin
                                // Squares have been steady on units b and c
                                uu_reg        <= mul_b_p;
                                dd_reg        <= mul_c_p;
                                lvl_reg       <= n_reg - ADDR_W'(1);
                                rd_idx_reg    <= '0;
                                rd_on_reg     <= 1'b1;
                                ret_valid_reg <= 1'b0;
                                m1_valid_reg  <= 1'b0;
                                m2_valid_reg  <= 1'b0;
                                state_reg     <= ST_LEVEL;
                            end
                        end
                    end
                end

                ST_LEVEL:
                begin
                    // Issue one node read per cycle
                    ret_valid_reg <= rd_on_reg;
                    ret_idx_reg   <= rd_idx_reg;
                    if (rd_on_reg)
                    begin
                        if (rd_last)
                            rd_on_reg <= 1'b0;
                        else
                            rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
                    end

                    // Slide the three-node window and start the branch products
                    m1_valid_reg <= 1'b0;
                    if (ret_valid_reg)
                    begin
                        w0_reg <= w1_reg;
                        w1_reg <= node_rdata;
                        if (ret_idx_reg >= ADDR_W'(2))
                        begin
                            m1_valid_reg <= 1'b1;
                            m1_j_reg     <= ret_idx_reg - ADDR_W'(2);
                            m1_ex_reg    <= q_sub(strike_q, spot_rdata);
                        end
                    end

                    m2_valid_reg <= m1_valid_reg;
                    m2_j_reg     <= m1_j_reg;
                    m2_ex_reg    <= m1_ex_reg;

                    // Write back in place; keep the low nodes for the greeks
                    if (m2_valid_reg)
                    begin
                        nwr_valid_reg <= 1'b1;
                        nwr_addr_reg  <= m2_j_reg;
                        nwr_data_reg  <= node_val;
                        for (int e = 0; e < 5; e++)
                        begin
                            if (m2_j_reg == ADDR_W'(e))
                                cap_reg[e] <= node_val;
                        end
                    end

                    // Level done once every write has landed
                    if (level_idle)
                    begin
                        if (lvl_reg == ADDR_W'(2))
                        begin
                            op_reg    <= OP_G_DIFF;
                            state_reg <= ST_GREEK;
                        end
                        else if (lvl_reg == ADDR_W'(1))
                        begin
                            op_reg    <= OP_D_DIFF;
                            state_reg <= ST_GREEK;
                        end
                        else if (lvl_reg == '0)
                        begin
                            op_reg    <= OP_THETA;
                            state_reg <= ST_GREEK;
                        end
                        else
                        begin
                            lvl_reg    <= lvl_reg - ADDR_W'(1);
                            rd_idx_reg <= '0;
                            rd_on_reg  <= 1'b1;
                        end
                    end
                end

                ST_GREEK:
                begin
                    if (!div_wait_reg)
                        div_wait_reg <= 1'b1;
                    else if (div_rsp.done)
                    begin
                        div_wait_reg <= 1'b0;
                        case (op_reg)
                            OP_G_DIFF: begin t0_reg <= div_rsp.quo; op_reg <= OP_G_A; end
                            OP_G_A:    begin t0_reg <= div_rsp.quo; op_reg <= OP_G_LOW; end
                            OP_G_LOW:  begin t1_reg <= div_rsp.quo; op_reg <= OP_G_B; end
                            OP_G_B:    begin t1_reg <= div_rsp.quo; op_reg <= OP_G_MIX; end
                            OP_G_MIX:  begin t0_reg <= div_rsp.quo; op_reg <= OP_GAMMA; end
                            OP_GAMMA:
                            begin
                                gamma_reg  <= div_rsp.quo;
                                lvl_reg    <= ADDR_W'(1);
                                rd_idx_reg <= '0;
                                rd_on_reg  <= 1'b1;
                                state_reg  <= ST_LEVEL;
                            end
                            OP_D_DIFF: begin t0_reg <= div_rsp.quo; op_reg <= OP_DELTA; end
                            OP_DELTA:
                            begin
                                delta_reg  <= div_rsp.quo;
                                lvl_reg    <= '0;
                                rd_idx_reg <= '0;
                                rd_on_reg  <= 1'b1;
                                state_reg  <= ST_LEVEL;
                            end
                            OP_THETA:
                            begin
                                theta_reg <= div_rsp.quo;
                                state_reg <= ST_DONE;
                            end
                            default:   state_reg <= ST_IDLE;
                        endcase
                    end
                end

                ST_DONE:
                begin
                    // Hand the result over once the output register is free
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_bad_reg   <= bad_reg;
                        out_value_reg <= bad_reg ? '0 : cap_reg[0];
                        out_delta_reg <= bad_reg ? '0 : delta_reg;
                        out_gamma_reg <= bad_reg ? '0 : gamma_reg;
                        out_theta_reg <= bad_reg ? '0 : theta_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_theta_reg, out_gamma_reg, out_delta_reg, out_value_reg};
    assign m_axis_tuser[0] = out_bad_reg;

endmodule

// ===== sv/tlop_checker.sv =====
module tlop_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // Stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Rejected step count carries zero payload
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("bad step result with nonzero payload");

    // One request in flight: ready drops after each accepted transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted back to back");

    // No result appears in the cycle right after a request was accepted
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result without computation");

endmodule

bind trinomial_lattice_option_pricer_top tlop_checker u_tlop_checker (.*);
